// File: rtl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when synthesising
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/smog_pkg.sv
//------------------------------------------------------------------------------
// smog_pkg
// shared types and constants of the median outlier gate
//------------------------------------------------------------------------------
package smog_pkg;

  localparam int KEY_W  = 64;
  localparam int DIST_W = 63;
  localparam int HIST_W = 10;
  localparam int OUT_W  = 72;

  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(3600000);
  localparam logic [HIST_W-1:0] HIST_RESET = HIST_W'(10);

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [0:0] {
    REG_MAX_DISTANCE = 1'b0,
    REG_MIN_HISTORY  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVICT,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    key_t     ins_key;
    key_t     old_key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_INSERT,
    S_GATHER,
    S_REDUCE,
    S_EMIT
  } state_t;

endpackage

// File: rtl/smog_cell.sv
//------------------------------------------------------------------------------
// smog_cell
// one slot of the sorted window, shifts left on evict and right on insert
//------------------------------------------------------------------------------
module smog_cell #(
  parameter int IDX = 0,
  parameter int CW  = 10
) (
  input  logic                clk,
  input  smog_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  smog_pkg::key_t      left_key,
  input  logic                left_live,
  input  smog_pkg::key_t      right_key,
  output smog_pkg::key_t      key,
  output logic                live
);

  logic at_end;

  assign live   = CW'(IDX) < count;
  assign at_end = CW'(IDX) == count;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      smog_pkg::CELL_EVICT: begin
        if (live && key >= ctrl.old_key) begin
          key <= right_key;
        end
      end
      smog_pkg::CELL_INSERT: begin
        if (left_live && left_key > ctrl.ins_key) begin
          key <= left_key;
        end else if (at_end || (live && key > ctrl.ins_key)) begin
          key <= ctrl.ins_key;
        end
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

// File: rtl/sliding_median_outlier_gate.sv
//------------------------------------------------------------------------------
// sliding_median_outlier_gate
// median watermark over a sliding window of timestamps, gates outliers
//------------------------------------------------------------------------------
// One timestamp per input beat; one result beat per input beat. The window is
// a sorted row of WINDOW cells: a full window first drops the oldest value
// (read from a circular store) in S_EVICT, then inserts the new one in
// S_INSERT, after which the upper median is picked out through a two-level
// registered select (S_GATHER, S_REDUCE). The result register is loaded in
// S_EMIT, and the next beat is taken only once the FSM is back in
// S_IDLE, so no new beat is taken before the current one is through. The
// result register lets the next beat in while the previous result waits; that
// item then holds in its last step until the waiting result has been taken.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_outlier_gate #(
  parameter int WINDOW = 1000
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [smog_pkg::KEY_W-1:0]  s_tdata,   // stamp
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [smog_pkg::OUT_W-1:0]  m_tdata,   // accepted, watermark, warming_up
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [smog_pkg::DIST_W-1:0] cfg_data
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int GS = 32;
  localparam int NG = (WINDOW + GS - 1) / GS;
  localparam int SW = CW + 1;
  localparam int HW = (CW > smog_pkg::HIST_W) ? CW : smog_pkg::HIST_W;

  smog_pkg::state_t state, state_next;
  smog_pkg::cell_ctrl_t ctrl;

  logic [smog_pkg::DIST_W-1:0] max_distance;
  logic [smog_pkg::HIST_W-1:0] min_history;
  logic [CW-1:0] fill;
  logic [AW-1:0] oldest;
  logic          full;
  logic          was_full;
  smog_pkg::key_t new_key;
  smog_pkg::key_t old_key;
  smog_pkg::key_t store [WINDOW];
  smog_pkg::key_t grp [NG];
  smog_pkg::key_t grp_next [NG];
  smog_pkg::key_t med;
  smog_pkg::key_t med_next;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot;
  logic [AW-1:0] oldest_inc;
  logic [CW-1:0] sel;
  logic          accept;

  smog_pkg::key_t cell_key [WINDOW];
  logic           cell_live [WINDOW];

  logic           warm;
  smog_pkg::key_t mark;
  logic [smog_pkg::KEY_W:0] diff;
  logic [smog_pkg::KEY_W:0] gap;
  logic           ok;
  logic           emit_go;
  logic [smog_pkg::OUT_W-1:0] result;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= smog_pkg::DIST_RESET;
      min_history  <= smog_pkg::HIST_RESET;
    end else if (cfg_we) begin
      case (smog_pkg::reg_index_t'(cfg_index))
        smog_pkg::REG_MAX_DISTANCE: max_distance <= cfg_data;
        smog_pkg::REG_MIN_HISTORY:  min_history  <= cfg_data[smog_pkg::HIST_W-1:0];
        default: ;
      endcase
    end
  end

  // fsm
  always_comb begin
    state_next = state;
    case (state)
      smog_pkg::S_IDLE:   if (accept) state_next = smog_pkg::S_EVICT;
      smog_pkg::S_EVICT:  state_next = smog_pkg::S_INSERT;
      smog_pkg::S_INSERT: state_next = smog_pkg::S_GATHER;
      smog_pkg::S_GATHER: state_next = smog_pkg::S_REDUCE;
      smog_pkg::S_REDUCE: state_next = smog_pkg::S_EMIT;
      smog_pkg::S_EMIT:   if (emit_go) state_next = smog_pkg::S_IDLE;
      default:            state_next = smog_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    ctrl.op      = smog_pkg::CELL_HOLD;
    ctrl.ins_key = new_key;
    ctrl.old_key = old_key;
    case (state)
      smog_pkg::S_IDLE:   s_tready = 1'b1;
      smog_pkg::S_EVICT:  if (was_full) ctrl.op = smog_pkg::CELL_EVICT;
      smog_pkg::S_INSERT: ctrl.op = smog_pkg::CELL_INSERT;
      default:            ctrl.op = smog_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= smog_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign accept = s_tvalid && s_tready;
  assign full   = fill == CW'(WINDOW);

  // circular store of arrival order
  assign slot_sum   = SW'(oldest) + SW'(fill);
  assign slot       = full ? oldest :
                      (slot_sum >= SW'(WINDOW)) ? AW'(slot_sum - SW'(WINDOW)) : AW'(slot_sum);
  assign oldest_inc = (oldest == AW'(WINDOW - 1)) ? '0 : oldest + AW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      old_key     <= store[oldest];
      store[slot] <= s_tdata ^ smog_pkg::SIGN_FLIP;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) new_key <= s_tdata ^ smog_pkg::SIGN_FLIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      oldest   <= '0;
      was_full <= 1'b0;
    end else begin
      if (accept) begin
        was_full <= full;
        if (full) oldest <= oldest_inc;
      end
      if (state == smog_pkg::S_EVICT && was_full) fill <= fill - CW'(1);
      if (state == smog_pkg::S_INSERT) fill <= fill + CW'(1);
    end
  end

  // sorted chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    smog_pkg::key_t lk;
    smog_pkg::key_t rk;
    logic           ll;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign ll = 1'b0;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign ll = cell_live[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign rk = '0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
    end
    smog_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (fill),
      .left_key  (lk),
      .left_live (ll),
      .right_key (rk),
      .key       (cell_key[i]),
      .live      (cell_live[i])
    );
  end

  // median select
  assign sel = fill >> 1;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GS; j++) begin
        if (g * GS + j < WINDOW) begin
          if (CW'(g * GS + j) == sel) grp_next[g] = grp_next[g] | cell_key[g * GS + j];
        end
      end
    end
  end

  always_comb begin
    med_next = '0;
    for (int g = 0; g < NG; g++) med_next = med_next | grp[g];
  end

  always_ff @(posedge clk) begin
    if (state == smog_pkg::S_GATHER) grp <= grp_next;
    if (state == smog_pkg::S_REDUCE) med <= med_next;
  end

  // gate and result register
  assign warm = HW'(fill) < HW'(min_history);
  assign mark = warm ? new_key : med;
  assign diff = {1'b0, new_key} - {1'b0, mark};
  assign gap  = diff[smog_pkg::KEY_W] ? ((~diff) + (smog_pkg::KEY_W+1)'(1)) : diff;
  assign ok   = warm || (gap <= (smog_pkg::KEY_W+1)'(max_distance));
  assign emit_go = (state == smog_pkg::S_EMIT) && (!m_tvalid || m_tready);
  assign result  = {{(smog_pkg::OUT_W-smog_pkg::KEY_W-2){1'b0}}, warm,
                    mark ^ smog_pkg::SIGN_FLIP, ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) m_tdata <= result;
  end

  `ASSERT_CLK(a_fill_bound, clk, rst, fill <= CW'(WINDOW))
  `ASSERT_CLK(a_oldest_bound, clk, rst, oldest <= AW'(WINDOW - 1))
  `ASSERT_CLK(a_accept_evict, clk, rst, accept |=> state == smog_pkg::S_EVICT)
  `ASSERT_CLK(a_emit_idle, clk, rst, emit_go |=> m_tvalid && state == smog_pkg::S_IDLE)

endmodule

// File: dv/tb.sv
//------------------------------------------------------------------------------
// tb
// stream testbench for the sliding median outlier gate: drives timestamps,
// rewrites both registers between phases, predicts each result beat and checks
//------------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 1000;
  localparam int QD = 64;
  localparam longint LIMIT = 3000000;

  class median_board;
    logic [63:0] ring [WIN];
    logic [63:0] sorted [$];
    int          held;
    int          head;
    logic [62:0] dist_lim;
    logic [9:0]  hist_lim;
    logic [71:0] pending [QD];
    int          rd_ptr;
    int          wr_ptr;
    int          waiting;
    int          errors;

    function void clear();
      held = 0; head = 0; sorted.delete();
      dist_lim = smog_pkg::DIST_RESET; hist_lim = smog_pkg::HIST_RESET;
      rd_ptr = 0; wr_ptr = 0; waiting = 0; errors = 0;
    endfunction

    function void note_stamp(logic [63:0] stamp);
      logic [63:0] key, mk, d;
      logic ok, warm;
      int pos;
      key = stamp ^ smog_pkg::SIGN_FLIP;
      if (held >= WIN) begin
        for (int i = 0; i < sorted.size(); i++)
          if (sorted[i] == ring[head]) begin
            sorted.delete(i);
            break;
          end
        ring[head] = key;
        head = (head + 1) % WIN;
      end else begin
        ring[(head + held) % WIN] = key;
        held++;
      end
      pos = sorted.size();
      while (pos > 0 && sorted[pos-1] > key) pos--;
      sorted.insert(pos, key);
      warm = held < hist_lim;
      if (warm) begin
        mk = key; ok = 1'b1;
      end else begin
        mk = sorted[held/2];
        d = (key >= mk) ? key - mk : mk - key;
        ok = d <= {1'b0, dist_lim};
      end
      if (waiting >= QD) begin
        $display("%0t too many results outstanding", $time);
        errors++;
        return;
      end
      pending[wr_ptr] = {6'b0, warm, mk ^ smog_pkg::SIGN_FLIP, ok};
      wr_ptr = (wr_ptr + 1) % QD;
      waiting++;
    endfunction

    function void check_result(logic [71:0] got);
      logic [71:0] exp;
      if (waiting == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QD;
      waiting--;
      if (got[0] !== exp[0]) begin
        $display("%0t accepted exp %b got %b", $time, exp[0], got[0]); errors++;
      end
      if (got[64:1] !== exp[64:1]) begin
        $display("%0t watermark exp %h got %h", $time, exp[64:1], got[64:1]); errors++;
      end
      if (got[65] !== exp[65]) begin
        $display("%0t warming_up exp %b got %b", $time, exp[65], got[65]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [63:0] s_tdata = 0;
  logic [71:0] m_tdata;
  logic cfg_we = 0;
  logic [0:0] cfg_index = smog_pkg::REG_MAX_DISTANCE;
  logic [62:0] cfg_data = 0;
  median_board board = new();
  longint cycles = 0;
  bit calm = 0;
  int sent = 0;

  sliding_median_outlier_gate #(.WINDOW(WIN)) u_dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= calm || ($urandom_range(99) >= 19);
  end

  task automatic write_reg(smog_pkg::reg_index_t idx, logic [62:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == smog_pkg::REG_MAX_DISTANCE) board.dist_lim = val;
    else board.hist_lim = val[9:0];
  endtask

  task automatic send_stamp(logic [63:0] v);
    while (!calm && $urandom_range(99) < 19) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_stamp(v);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] near_stamp(logic [63:0] base, int span);
    return base + 64'($signed($urandom_range(2*span) - span));
  endfunction

  initial begin
    logic [63:0] base;
    board.clear();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset settings, warm-up then extremes
    send_stamp(64'h8000000000000000);
    send_stamp(64'h7fffffffffffffff);
    send_stamp(64'hffffffffffffffff);
    send_stamp(64'h0);
    for (int i = 0; i < 8; i++) send_stamp(64'(i * 1000000));
    send_stamp(64'h7fffffffffffffff);
    send_stamp(64'h8000000000000000);
    send_stamp(64'(3500000));
    drain();
    write_reg(smog_pkg::REG_MAX_DISTANCE, 63'h7fffffffffffffff);
    write_reg(smog_pkg::REG_MIN_HISTORY, 10'd0);
    send_stamp(64'h8000000000000000);
    send_stamp(64'h7fffffffffffffff);
    send_stamp(64'h5555555555555555);
    drain();
    write_reg(smog_pkg::REG_MAX_DISTANCE, 63'd0);
    send_stamp(64'h0);
    send_stamp(64'haaaaaaaaaaaaaaaa);
    drain();
    // random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'd1);
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'd500);
        end
        1: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'h3ff);
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'd0);
        end
        2: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'd1000);
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'd3600000);
        end
        3: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'd999);
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'($urandom));
        end
        4: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'($urandom_range(1, 40)));
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'({$urandom, $urandom}));
        end
        default: begin
          write_reg(smog_pkg::REG_MIN_HISTORY, 10'd10);
          write_reg(smog_pkg::REG_MAX_DISTANCE, 63'd2000);
        end
      endcase
      base = rnd64();
      for (int k = 0; k < 180; k++) begin
        case ($urandom_range(9))
          0: send_stamp(rnd64());
          1: send_stamp($urandom_range(1) ? 64'h7fffffffffffffff : 64'h8000000000000000);
          2: send_stamp(near_stamp(base, 10));
          default: send_stamp(near_stamp(base, 3000));
        endcase
      end
      drain();
    end
    calm = 0;
    $display("%0d stamps sent over warm-up, full-window eviction, extremes and six settings",
             sent);
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// File: sliding_median_outlier_gate.f
+incdir+rtl
rtl/smog_pkg.sv
rtl/smog_cell.sv
rtl/sliding_median_outlier_gate.sv
dv/tb.sv
